/* rtl/keep_last_frame_ring_queue_defines.svh */
// Assertion macros for the keep-last frame ring queue.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef KEEP_LAST_FRAME_RING_QUEUE_DEFINES_SVH
`define KEEP_LAST_FRAME_RING_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define KLFRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies another on the next clock edge.
`define KLFRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KLFRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define KLFRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/klfrq_pkg.sv */
// Shared types and constants of the keep-last frame ring queue.
// No dependencies; imported by keep_last_frame_ring_queue.
package klfrq_pkg;

  // Fixed port widths
  localparam int CMD_W     = 3;
  localparam int FRAME_W   = 32;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 3'd0,
    CMD_PEEK      = 3'd1,
    CMD_PEEK_LAST = 3'd2,
    CMD_NEXT      = 3'd3,
    CMD_CONSUME   = 3'd4,
    CMD_FLUSH     = 3'd5,
    CMD_ABORT     = 3'd6,
    CMD_START     = 3'd7
  } cmd_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_LAST  = 1'd1;

endpackage

/* rtl/keep_last_frame_ring_queue.sv */
// Keep-last ring queue of frame handles: slot memory, indices, counters, result stage.
// Depends on klfrq_pkg and keep_last_frame_ring_queue_defines.svh.

// The queue takes one command in every clock cycle: busy_o never rises, so a
// command is accepted whenever start_i is high. Its result appears on the
// result ports in the next cycle, for one cycle, marked by done_o; the
// receiver must take it then. The result stage is registered, as is the slot
// memory, whose registered read supplies frame_out_o for peeks. Indices and
// counts update at the accepting edge, so a command sees the effect of the
// one just before it. Configuration writes are always ready and take effect
// at the next edge.
`include "keep_last_frame_ring_queue_defines.svh"

module keep_last_frame_ring_queue #(
  parameter int SLOTS       = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [klfrq_pkg::CMD_W-1:0]       cmd_i,
  input  logic [klfrq_pkg::FRAME_W-1:0]     frame_in_i,
  // result channel
  output logic                              done_o,
  output logic                              ok_o,
  output logic [klfrq_pkg::FRAME_W-1:0]     frame_out_o,
  output logic [klfrq_pkg::COUNT_W-1:0]     occupancy_o,
  output logic [klfrq_pkg::COUNT_W-1:0]     readable_o,
  // configuration channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [klfrq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [klfrq_pkg::CFG_W-1:0]       cfg_data_i
);
  import klfrq_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = (HANDLE_BITS < FRAME_W) ? HANDLE_BITS : FRAME_W;

  // Wrap an index at the active slot count
  function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx, input logic [CW-1:0] lim);
    logic [CW:0] n;
    n = (CW+1)'(idx) + 1'b1;
    return (n >= (CW+1)'(lim)) ? '0 : IW'(n);
  endfunction

  // Slot memory
  logic [SW-1:0] mem [SLOTS];
  logic [SW-1:0] rdata_q;

  // Queue state
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [IW-1:0] wr_idx_q, wr_idx_d;
  logic [CW-1:0] held_q, held_d;
  logic          shown_q, shown_d;
  logic          aborted_q, aborted_d;
  logic [CFG_W-1:0] max_frames_q;
  logic          keep_last_q;

  // Result stage
  logic               done_q, ok_q, ok_d, use_mem_q, use_mem_d;
  logic [COUNT_W-1:0] occ_q, occ_d, rdbl_q, rdbl_d;

  logic          accept;
  cmd_e          cmd;
  logic [CW-1:0] limit;
  logic          kept_now;
  logic [CW-1:0] readable_now;
  logic [CW-1:0] readable_nxt;
  logic          mem_we, mem_re;
  logic [IW-1:0] raddr;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign cmd         = cmd_e'(cmd_i);

  // Clamp the slot count into 1..SLOTS
  always_comb begin
    if (max_frames_q == '0) begin
      limit = CW'(1);
    end else if (32'(max_frames_q) > 32'(SLOTS)) begin
      limit = CW'(SLOTS);
    end else begin
      limit = CW'(max_frames_q);
    end
  end

  assign kept_now     = keep_last_q && shown_q;
  assign readable_now = (held_q > CW'(kept_now)) ? held_q - CW'(kept_now) : '0;

  // Decode the command and compute the next queue state
  always_comb begin
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    held_d    = held_q;
    shown_d   = shown_q;
    aborted_d = aborted_q;
    ok_d      = 1'b0;
    use_mem_d = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    raddr     = rd_idx_q;
    case (cmd)
      CMD_PUSH: begin
        if (!aborted_q && held_q < limit) begin
          mem_we   = 1'b1;
          wr_idx_d = adv(wr_idx_q, limit);
          held_d   = held_q + 1'b1;
          ok_d     = 1'b1;
        end
      end
      CMD_PEEK: begin
        if (readable_now != '0) begin
          raddr     = kept_now ? adv(rd_idx_q, limit) : rd_idx_q;
          mem_re    = 1'b1;
          use_mem_d = 1'b1;
          ok_d      = 1'b1;
        end
      end
      CMD_PEEK_LAST: begin
        if (kept_now && held_q != '0) begin
          mem_re    = 1'b1;
          use_mem_d = 1'b1;
          ok_d      = 1'b1;
        end
      end
      CMD_NEXT, CMD_CONSUME: begin
        if (held_q != '0) begin
          if (keep_last_q && !shown_q) begin
            shown_d = 1'b1;
          end else begin
            rd_idx_d = adv(rd_idx_q, limit);
            held_d   = held_q - 1'b1;
            if (keep_last_q) begin
              shown_d = (cmd == CMD_CONSUME) && (held_q != CW'(1));
            end
          end
          ok_d = 1'b1;
        end
      end
      CMD_FLUSH: begin
        rd_idx_d = '0;
        wr_idx_d = '0;
        held_d   = '0;
        shown_d  = 1'b0;
        ok_d     = 1'b1;
      end
      CMD_ABORT: begin
        aborted_d = 1'b1;
        ok_d      = 1'b1;
      end
      CMD_START: begin
        aborted_d = 1'b0;
        ok_d      = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Counts reported after the command
  assign readable_nxt = (held_d > CW'(keep_last_q && shown_d))
                      ? held_d - CW'(keep_last_q && shown_d) : '0;
  assign occ_d  = COUNT_W'(held_d);
  assign rdbl_d = COUNT_W'(readable_nxt);

  // Write and read the slot memory
  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      mem[wr_idx_q] <= frame_in_i[SW-1:0];
    end
    if (accept && mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Advance queue state on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      wr_idx_q  <= '0;
      held_q    <= '0;
      shown_q   <= 1'b0;
      aborted_q <= 1'b0;
    end else if (accept) begin
      rd_idx_q  <= rd_idx_d;
      wr_idx_q  <= wr_idx_d;
      held_q    <= held_d;
      shown_q   <= shown_d;
      aborted_q <= aborted_d;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frames_q <= CFG_W'(16);
      keep_last_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MAX_FRAMES: max_frames_q <= cfg_data_i;
        REG_KEEP_LAST:  keep_last_q  <= cfg_data_i[0];
        default:        max_frames_q <= max_frames_q;
      endcase
    end
  end

  // Hold the result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q      <= ok_d;
      use_mem_q <= use_mem_d;
      occ_q     <= occ_d;
      rdbl_q    <= rdbl_d;
    end
  end

  assign done_o      = done_q;
  assign ok_o        = done_q && ok_q;
  assign frame_out_o = (done_q && ok_q && use_mem_q) ? FRAME_W'(rdata_q) : '0;
  assign occupancy_o = occ_q;
  assign readable_o  = rdbl_q;

  `KLFRQ_ASSERT_NEXT(a_done_follows, clk_i, rst_ni, accept, done_q, "result strobe missing")
  `KLFRQ_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !accept, !done_q, "result without item")
  `KLFRQ_ASSERT_NEXT(a_push_count, clk_i, rst_ni, accept && mem_we,
                     held_q == $past(held_q) + 1'b1, "push did not bump count")
  `KLFRQ_ASSERT(a_held_bound, clk_i, rst_ni, 32'(held_q) <= 32'(SLOTS), "count past slots")
  `KLFRQ_ASSERT(a_mem_ok, clk_i, rst_ni, !(done_q && use_mem_q) || ok_q, "read without ok")

endmodule
